@@ src/assert_macros.svh @@
// Assertion macros used by pecc_checker.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PECC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PECC_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pecc_pkg.sv @@
// Shared types and constants of the ping echo packet classifier.
// No dependencies; used by every module of the block.
package pecc_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        drop_frame;
    logic [2:0]  status;
    logic [15:0] echo_sequence_out;
  } out_item_t;

  // Layer 3 kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_V4    = 2'd1;
  localparam logic [1:0] KIND_V6    = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // Verdict status codes
  localparam logic [2:0] ST_NOT_IP    = 3'd0;
  localparam logic [2:0] ST_MALFORMED = 3'd1;
  localparam logic [2:0] ST_NOT_ICMP  = 3'd2;
  localparam logic [2:0] ST_NOT_ECHO  = 3'd3;
  localparam logic [2:0] ST_ODD_ECHO  = 3'd4;
  localparam logic [2:0] ST_EVEN_ECHO = 3'd5;

  localparam logic [1:0]  MAX_VLAN_TAGS   = 2'd2;
  localparam logic [15:0] TPID_CTAG       = 16'h8100;
  localparam logic [15:0] TPID_STAG       = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6      = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  PROTO_ICMPV6    = 8'd58;
  localparam logic [7:0]  ICMPV4_PING_REQ = 8'd8;
  localparam logic [7:0]  ICMPV6_PING_REQ = 8'd128;
  localparam logic [4:0]  ETH_HDR_BYTES   = 5'd14;
  localparam logic [4:0]  VLAN_TAG_BYTES  = 5'd4;
  localparam logic [5:0]  IPV4_MIN_BYTES  = 6'd20;
  localparam logic [5:0]  IPV6_HDR_BYTES  = 6'd40;
  localparam logic [5:0]  ICMP_HDR_BYTES  = 6'd8;

  // Header summary of one finished frame, handed from parser to verdict stage
  typedef struct packed {
    logic [16:0] len;
    logic [4:0]  l3_start;
    logic        tag_open;
    logic [1:0]  l3_kind;
    logic [5:0]  ip_hdr_bytes;
    logic [7:0]  next_proto;
    logic [7:0]  icmp_type;
    logic [15:0] echo_seq;
  } summary_t;

endpackage

@@ src/ping_echo_packet_classifier_core.sv @@
// Ping echo packet classifier, top level.
// Instantiates pecc_front, pecc_queue and pecc_back; uses pecc_pkg.
//
// Input channel: one frame byte per transfer (in_push high, in_full low),
// starting at the destination MAC, with last_byte set on the final byte.
// Output channel: one verdict per frame, shown while out_empty is low and
// taken with out_pop. drop_frame is set only for an echo request with an
// even sequence number; status tells why a frame passes.
// Throughput: one byte per cycle while in_full is low, set by the parser which handles every
// byte in the cycle it is transferred.
// The transfer of the last byte writes the frame summary to the summary queue; from
// there it loads the output register when that is empty or being drained.
// A stalled receiver fills the output register and then the summary queue
// (QUEUE_DEPTH frames); in_full rises only when the queue is full, and bytes
// of frames still in progress keep flowing until then.
// Reset (rst_n low, synchronous) clears the parser, empties the queue and
// the output register; the first byte may be pushed in the next cycle.
module ping_echo_packet_classifier_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  pecc_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output pecc_pkg::out_item_t out_item
);

  logic               accept;
  logic               sum_push;
  pecc_pkg::summary_t sum_in;
  pecc_pkg::summary_t sum_head;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               out_valid;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign out_empty = !out_valid;

  pecc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .sum_push (sum_push),
    .sum_data (sum_in)
  );

  pecc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (sum_push),
    .din   (sum_in),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .dout  (sum_head)
  );

  pecc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (q_valid),
    .sum_data  (sum_head),
    .sum_pop   (q_pop),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

@@ src/pecc_front.sv @@
// Byte-wide header parser: Ethernet, VLAN tags, IPv4/IPv6, ICMP echo fields.
// Emits one header summary per frame on its last byte. Uses pecc_pkg.
module pecc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  pecc_pkg::in_item_t  item,
  output logic                sum_push,
  output pecc_pkg::summary_t  sum_data
);

  logic [15:0] off_r, off_nxt;
  logic [15:0] ether_r, ether_nxt;
  logic [1:0]  tags_r, tags_nxt;
  logic [4:0]  start_r, start_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [5:0]  ihb_r, ihb_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [7:0]  icmp_r, icmp_nxt;
  logic [15:0] seq_r, seq_nxt;

  logic [7:0]  b;
  logic [15:0] rel;
  logic [15:0] r;
  logic        more_nxt;

  function automatic logic more_tags(input logic [15:0] et, input logic [1:0] seen);
    return ((et == pecc_pkg::TPID_CTAG) || (et == pecc_pkg::TPID_STAG)) &&
           (seen < pecc_pkg::MAX_VLAN_TAGS);
  endfunction

  function automatic logic [1:0] kind_of(input logic [15:0] et);
    if (et == pecc_pkg::ETYPE_IPV4) return pecc_pkg::KIND_V4;
    if (et == pecc_pkg::ETYPE_IPV6) return pecc_pkg::KIND_V6;
    return pecc_pkg::KIND_OTHER;
  endfunction

  assign b = item.packet_byte;

  always_comb begin
    off_nxt   = off_r;
    ether_nxt = ether_r;
    tags_nxt  = tags_r;
    start_nxt = start_r;
    kind_nxt  = kind_r;
    ihb_nxt   = ihb_r;
    proto_nxt = proto_r;
    icmp_nxt  = icmp_r;
    seq_nxt   = seq_r;
    rel       = off_r - {11'd0, start_r};
    r         = rel - {10'd0, ihb_r};

    if (kind_r == pecc_pkg::KIND_NONE) begin
      if (({1'b0, off_r} + 17'd2) == {12'd0, start_r}) begin
        ether_nxt = {b, ether_r[7:0]};
      end else if (({1'b0, off_r} + 17'd1) == {12'd0, start_r}) begin
        ether_nxt = {ether_r[15:8], b};
      end else if (off_r == {11'd0, start_r}) begin
        if (more_tags(ether_r, tags_r)) begin
          tags_nxt  = tags_r + 2'd1;
          start_nxt = start_r + pecc_pkg::VLAN_TAG_BYTES;
        end else begin
          kind_nxt = kind_of(ether_r);
        end
      end
    end

    if (((kind_nxt == pecc_pkg::KIND_V4) || (kind_nxt == pecc_pkg::KIND_V6)) &&
        (off_r >= {11'd0, start_r})) begin
      if (rel == 16'd0) begin
        ihb_nxt = (kind_nxt == pecc_pkg::KIND_V4) ? {b[3:0], 2'b00}
                                                  : pecc_pkg::IPV6_HDR_BYTES;
      end
      if ((kind_nxt == pecc_pkg::KIND_V4) && (rel == 16'd9)) proto_nxt = b;
      if ((kind_nxt == pecc_pkg::KIND_V6) && (rel == 16'd6)) proto_nxt = b;
      // ICMP fields follow the IP header; header length is known from rel 0 on
      if ((rel != 16'd0) && (ihb_r >= pecc_pkg::IPV4_MIN_BYTES) &&
          (rel >= {10'd0, ihb_r})) begin
        if (r == 16'd0) icmp_nxt = b;
        else if (r == 16'd6) seq_nxt = {b, seq_r[7:0]};
        else if (r == 16'd7) seq_nxt = {seq_r[15:8], b};
      end
    end

    if (off_r != 16'hFFFF) off_nxt = off_r + 16'd1;

    more_nxt = more_tags(ether_nxt, tags_nxt);
  end

  always_comb begin
    sum_push              = accept && item.last_byte;
    sum_data.len          = {1'b0, off_r} + 17'd1;
    sum_data.l3_start     = start_nxt;
    sum_data.tag_open     = (kind_nxt == pecc_pkg::KIND_NONE) && more_nxt;
    sum_data.l3_kind      = (kind_nxt == pecc_pkg::KIND_NONE) ? kind_of(ether_nxt) : kind_nxt;
    sum_data.ip_hdr_bytes = ihb_nxt;
    sum_data.next_proto   = proto_nxt;
    sum_data.icmp_type    = icmp_nxt;
    sum_data.echo_seq     = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && item.last_byte)) begin
      off_r   <= 16'd0;
      ether_r <= 16'd0;
      tags_r  <= 2'd0;
      start_r <= pecc_pkg::ETH_HDR_BYTES;
      kind_r  <= pecc_pkg::KIND_NONE;
      ihb_r   <= 6'd0;
      proto_r <= 8'd0;
      icmp_r  <= 8'd0;
      seq_r   <= 16'd0;
    end else if (accept) begin
      off_r   <= off_nxt;
      ether_r <= ether_nxt;
      tags_r  <= tags_nxt;
      start_r <= start_nxt;
      kind_r  <= kind_nxt;
      ihb_r   <= ihb_nxt;
      proto_r <= proto_nxt;
      icmp_r  <= icmp_nxt;
      seq_r   <= seq_nxt;
    end
  end

endmodule

@@ src/pecc_queue.sv @@
// Small first-in first-out queue of frame summaries between parser and verdict.
// Uses pecc_pkg for the summary type.
module pecc_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pecc_pkg::summary_t din,
  output logic               full,
  output logic               valid,
  input  logic               pop,
  output pecc_pkg::summary_t dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pecc_pkg::summary_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

@@ src/pecc_back.sv @@
// Verdict stage: turns a frame summary into drop/pass and status, and holds
// the result in an output register until it is taken. Uses pecc_pkg.
module pecc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                sum_valid,
  input  pecc_pkg::summary_t  sum_data,
  output logic                sum_pop,
  output logic                out_valid,
  input  logic                out_pop,
  output pecc_pkg::out_item_t out_item
);

  logic                out_valid_r;
  pecc_pkg::out_item_t out_item_r, out_item_nxt;
  logic [2:0]          st;
  logic [16:0]         rest;
  logic [16:0]         after_ip;
  logic                is_v4;

  assign is_v4    = (sum_data.l3_kind == pecc_pkg::KIND_V4);
  assign rest     = sum_data.len - {12'd0, sum_data.l3_start};
  assign after_ip = rest - {11'd0, sum_data.ip_hdr_bytes};

  always_comb begin
    if (sum_data.len < {12'd0, sum_data.l3_start}) begin
      st = pecc_pkg::ST_MALFORMED;
    end else if (sum_data.tag_open) begin
      st = pecc_pkg::ST_MALFORMED;
    end else if ((sum_data.l3_kind != pecc_pkg::KIND_V4) &&
                 (sum_data.l3_kind != pecc_pkg::KIND_V6)) begin
      st = pecc_pkg::ST_NOT_IP;
    end else if (is_v4 && ((rest < {11'd0, pecc_pkg::IPV4_MIN_BYTES}) ||
                           (sum_data.ip_hdr_bytes < pecc_pkg::IPV4_MIN_BYTES) ||
                           (rest < {11'd0, sum_data.ip_hdr_bytes}))) begin
      st = pecc_pkg::ST_MALFORMED;
    end else if (!is_v4 && (rest < {11'd0, pecc_pkg::IPV6_HDR_BYTES})) begin
      st = pecc_pkg::ST_MALFORMED;
    end else if (sum_data.next_proto !=
                 (is_v4 ? pecc_pkg::PROTO_ICMP : pecc_pkg::PROTO_ICMPV6)) begin
      st = pecc_pkg::ST_NOT_ICMP;
    end else if (after_ip < {11'd0, pecc_pkg::ICMP_HDR_BYTES}) begin
      st = pecc_pkg::ST_MALFORMED;
    end else if (sum_data.icmp_type !=
                 (is_v4 ? pecc_pkg::ICMPV4_PING_REQ : pecc_pkg::ICMPV6_PING_REQ)) begin
      st = pecc_pkg::ST_NOT_ECHO;
    end else begin
      st = sum_data.echo_seq[0] ? pecc_pkg::ST_ODD_ECHO : pecc_pkg::ST_EVEN_ECHO;
    end

    out_item_nxt.drop_frame        = (st == pecc_pkg::ST_EVEN_ECHO);
    out_item_nxt.status            = st;
    out_item_nxt.echo_sequence_out =
      ((st == pecc_pkg::ST_ODD_ECHO) || (st == pecc_pkg::ST_EVEN_ECHO)) ?
      sum_data.echo_seq : 16'd0;
  end

  // Refill the output register whenever it is empty or being drained
  assign sum_pop   = sum_valid && (!out_valid_r || out_pop);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_pop) out_item_r <= out_item_nxt;
  end

endmodule

@@ src/pecc_checker.sv @@
// Port-level checks of the ping echo packet classifier, bound to the top.
// Uses pecc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pecc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input pecc_pkg::in_item_t  in_item,
  input logic                out_empty,
  input logic                out_pop,
  input pecc_pkg::out_item_t out_item
);

  // Drop decision must agree with the status code
  `PECC_ASSERT(a_drop_matches_status, clk, rst_n, !out_empty |-> (out_item.drop_frame == (out_item.status == pecc_pkg::ST_EVEN_ECHO)), "drop_frame disagrees with status")

  // Sequence is reported only for echo requests
  `PECC_ASSERT(a_seq_only_for_echo, clk, rst_n, (!out_empty && (out_item.status != pecc_pkg::ST_ODD_ECHO) && (out_item.status != pecc_pkg::ST_EVEN_ECHO)) |-> (out_item.echo_sequence_out == 16'd0), "sequence set for a non-echo verdict")

  // A waiting result holds until transferred
  `PECC_ASSERT(a_result_holds, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)), "waiting result changed")

  // Reset leaves both channels empty and open
  `PECC_ASSERT_ALL(a_reset_clears, clk, !rst_n |=> (out_empty && !in_full), "reset did not clear the channels")

endmodule

bind ping_echo_packet_classifier_core pecc_checker u_pecc_checker (.*);

@@ tb/pecc_verdict_checker.sv @@
`timescale 1ns / 100ps
// Watches both channels of the ping echo packet classifier, predicts each frame verdict
// and compares it with what the block returns. Depends on pecc_pkg.
module pecc_verdict_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  pecc_pkg::in_item_t  in_item,
  input  logic                out_empty,
  input  logic                out_pop,
  input  pecc_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  verdicts_open
);

  // parser state of the frame in progress
  logic [15:0] offset_q;
  logic [15:0] etype_q;
  logic [1:0]  tags_q;
  logic [4:0]  l3_base_q;
  logic [1:0]  kind_q;
  logic [5:0]  ip_len_q;
  logic [7:0]  proto_q;
  logic [7:0]  icmp_type_q;
  logic [15:0] seq_q;

  pecc_pkg::out_item_t verdicts_due[$];

  task automatic clear_parser();
    offset_q    = '0;
    etype_q     = '0;
    tags_q      = '0;
    l3_base_q   = pecc_pkg::ETH_HDR_BYTES;
    kind_q      = pecc_pkg::KIND_NONE;
    ip_len_q    = '0;
    proto_q     = '0;
    icmp_type_q = '0;
    seq_q       = '0;
  endtask

  function automatic bit tag_pending();
    return (etype_q == pecc_pkg::TPID_CTAG || etype_q == pecc_pkg::TPID_STAG) &&
           tags_q < pecc_pkg::MAX_VLAN_TAGS;
  endfunction

  function automatic logic [1:0] kind_from_type();
    if (etype_q == pecc_pkg::ETYPE_IPV4) return pecc_pkg::KIND_V4;
    if (etype_q == pecc_pkg::ETYPE_IPV6) return pecc_pkg::KIND_V6;
    return pecc_pkg::KIND_OTHER;
  endfunction

  function automatic logic [2:0] classify(int len);
    logic [1:0] k;
    int rest;
    k = kind_q;
    if (len < int'(l3_base_q)) return pecc_pkg::ST_MALFORMED;
    if (k == pecc_pkg::KIND_NONE) begin
      // frame ended right where another tag would be read
      if (tag_pending()) return pecc_pkg::ST_MALFORMED;
      k = kind_from_type();
    end
    if (k == pecc_pkg::KIND_OTHER) return pecc_pkg::ST_NOT_IP;
    rest = len - int'(l3_base_q);
    if (k == pecc_pkg::KIND_V4) begin
      if (rest < int'(pecc_pkg::IPV4_MIN_BYTES)) return pecc_pkg::ST_MALFORMED;
      if (ip_len_q < pecc_pkg::IPV4_MIN_BYTES) return pecc_pkg::ST_MALFORMED;
      if (rest < int'(ip_len_q)) return pecc_pkg::ST_MALFORMED;
      if (proto_q != pecc_pkg::PROTO_ICMP) return pecc_pkg::ST_NOT_ICMP;
    end else begin
      if (rest < int'(pecc_pkg::IPV6_HDR_BYTES)) return pecc_pkg::ST_MALFORMED;
      if (proto_q != pecc_pkg::PROTO_ICMPV6) return pecc_pkg::ST_NOT_ICMP;
    end
    if (rest - int'(ip_len_q) < int'(pecc_pkg::ICMP_HDR_BYTES)) return pecc_pkg::ST_MALFORMED;
    if (icmp_type_q != ((k == pecc_pkg::KIND_V4) ? pecc_pkg::ICMPV4_PING_REQ
                                                 : pecc_pkg::ICMPV6_PING_REQ))
      return pecc_pkg::ST_NOT_ECHO;
    return seq_q[0] ? pecc_pkg::ST_ODD_ECHO : pecc_pkg::ST_EVEN_ECHO;
  endfunction

  task automatic parse_byte(input pecc_pkg::in_item_t it);
    int                  o;
    int                  rel;
    int                  r;
    logic [7:0]          b;
    logic [2:0]          st;
    pecc_pkg::out_item_t v;
    b = it.packet_byte;
    o = int'(offset_q);
    if (kind_q == pecc_pkg::KIND_NONE) begin
      if (o + 2 == int'(l3_base_q)) etype_q[15:8] = b;
      else if (o + 1 == int'(l3_base_q)) etype_q[7:0] = b;
      else if (o == int'(l3_base_q)) begin
        if (tag_pending()) begin
          tags_q    = tags_q + 2'd1;
          l3_base_q = l3_base_q + pecc_pkg::VLAN_TAG_BYTES;
        end else begin
          kind_q = kind_from_type();
        end
      end
    end
    if ((kind_q == pecc_pkg::KIND_V4 || kind_q == pecc_pkg::KIND_V6) &&
        o >= int'(l3_base_q)) begin
      rel = o - int'(l3_base_q);
      if (rel == 0)
        ip_len_q = (kind_q == pecc_pkg::KIND_V4) ? {b[3:0], 2'b00} : pecc_pkg::IPV6_HDR_BYTES;
      if (kind_q == pecc_pkg::KIND_V4 && rel == 9) proto_q = b;
      if (kind_q == pecc_pkg::KIND_V6 && rel == 6) proto_q = b;
      if (rel > 0 && ip_len_q >= pecc_pkg::IPV4_MIN_BYTES && rel >= int'(ip_len_q)) begin
        r = rel - int'(ip_len_q);
        if (r == 0) icmp_type_q = b;
        else if (r == 6) seq_q[15:8] = b;
        else if (r == 7) seq_q[7:0] = b;
      end
    end
    // hold the offset once it saturates
    if (offset_q != 16'hFFFF) offset_q = offset_q + 16'd1;
    if (it.last_byte) begin
      st = classify(o + 1);
      v.drop_frame        = (st == pecc_pkg::ST_EVEN_ECHO);
      v.status            = st;
      v.echo_sequence_out = (st >= pecc_pkg::ST_ODD_ECHO) ? seq_q : 16'h0000;
      verdicts_due.push_back(v);
      clear_parser();
    end
  endtask

  task automatic check_verdict(input pecc_pkg::out_item_t got);
    pecc_pkg::out_item_t want;
    if (verdicts_due.size() == 0) begin
      $error("verdict with none pending: drop_frame %0d status %0d echo_sequence_out %h",
             got.drop_frame, got.status, got.echo_sequence_out);
      fail_count++;
    end else begin
      want = verdicts_due.pop_front();
      if (got.drop_frame !== want.drop_frame) begin
        $error("drop_frame: expected %0d, actual %0d", want.drop_frame, got.drop_frame);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.echo_sequence_out !== want.echo_sequence_out) begin
        $error("echo_sequence_out: expected %h, actual %h",
               want.echo_sequence_out, got.echo_sequence_out);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      verdicts_due.delete();
    end else begin
      if (out_pop && !out_empty) check_verdict(out_item);
      if (in_push && !in_full) parse_byte(in_item);
    end
    verdicts_open = verdicts_due.size();
  end

endmodule

@@ tb/tb_ping_echo_packet_classifier_core.sv @@
`timescale 1ns / 100ps
// Top of the ping echo packet classifier testbench: clock, reset, frame stimulus, pop pacing
// and the verdict. Depends on pecc_pkg, pecc_verdict_checker and the block itself.
module tb_ping_echo_packet_classifier_core;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  pecc_pkg::in_item_t  in_item = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  pecc_pkg::out_item_t out_item;

  int fail_count;
  int verdicts_open;
  int cycles;
  int bytes_sent;
  int frames_sent;
  int pop_hold;
  int pop_mode;

  logic [7:0] frame_bytes[$];

  always #6 clk = ~clk;

  ping_echo_packet_classifier_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  pecc_verdict_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_item       (in_item),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .verdicts_open (verdicts_open)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ping_echo_packet_classifier_core: errors");
      $finish;
    end
  end

  // receiver pacing: modes switch now and then between no stalls, short and long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 199) == 0) pop_mode = $urandom_range(0, 2);
      case (pop_mode)
        1: if ($urandom_range(0, 9) < 3) pop_hold = $urandom_range(1, 3);
        2: begin
          if ($urandom_range(0, 99) < 3) pop_hold = $urandom_range(15, 40);
          else if ($urandom_range(0, 9) == 0) pop_hold = $urandom_range(1, 3);
        end
        default: pop_hold = 0;
      endcase
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // MAC addresses, tags, L3 header, ICMP header, payload; then cut to cut_len if nonzero
  task automatic build_frame(input int n_tags, input logic [15:0] l3_type,
                             input logic [3:0] ihl, input logic [7:0] proto,
                             input logic [7:0] icmp_type, input logic [15:0] seq,
                             input int payload, input int cut_len);
    int          i;
    int          hdr_len;
    logic [15:0] tpid;
    logic [3:0]  ver;
    frame_bytes.delete();
    repeat (12) frame_bytes.push_back(8'($urandom));
    for (i = 0; i < n_tags; i++) begin
      tpid = $urandom_range(0, 1) ? pecc_pkg::TPID_CTAG : pecc_pkg::TPID_STAG;
      frame_bytes.push_back(tpid[15:8]);
      frame_bytes.push_back(tpid[7:0]);
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(l3_type[15:8]);
    frame_bytes.push_back(l3_type[7:0]);
    if (l3_type == pecc_pkg::ETYPE_IPV4) begin
      hdr_len = (ihl < 4'd5) ? 20 : 4 * int'(ihl);
      ver = ($urandom_range(0, 7) != 0) ? 4'd4 : 4'($urandom);
      frame_bytes.push_back({ver, ihl});
      for (i = 1; i < hdr_len; i++) frame_bytes.push_back((i == 9) ? proto : 8'($urandom));
    end else if (l3_type == pecc_pkg::ETYPE_IPV6) begin
      frame_bytes.push_back({4'd6, 4'($urandom)});
      for (i = 1; i < 40; i++) frame_bytes.push_back((i == 6) ? proto : 8'($urandom));
    end else begin
      repeat (20) frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(icmp_type);
    repeat (5) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(seq[15:8]);
    frame_bytes.push_back(seq[7:0]);
    repeat (payload) frame_bytes.push_back(8'($urandom));
    if (cut_len > 0)
      while (frame_bytes.size() > cut_len) void'(frame_bytes.pop_back());
  endtask

  task automatic send_frame(input bit paced);
    int i;
    int gap;
    for (i = 0; i < frame_bytes.size(); i++) begin
      gap = paced ? idle_cycles() : 0;
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_push <= 1'b1;
      in_item <= '{packet_byte: frame_bytes[i], last_byte: (i == frame_bytes.size() - 1)};
      do @(posedge clk); while (in_full);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  task automatic run_frame(input int n_tags, input logic [15:0] l3_type,
                           input logic [3:0] ihl, input logic [7:0] proto,
                           input logic [7:0] icmp_type, input logic [15:0] seq,
                           input int payload, input int cut_len, input bit paced);
    build_frame(n_tags, l3_type, ihl, proto, icmp_type, seq, payload, cut_len);
    send_frame(paced);
  endtask

  initial begin
    int          r;
    int          n_tags;
    logic [15:0] l3_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  icmp_type;
    int          cut_len;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // single byte, truncated Ethernet header, frame ending where a tag would start
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 0, 1, 1'b0);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 0, 13, 1'b1);
    run_frame(1, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 0, 14, 1'b0);
    run_frame(1, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 0, 18, 1'b1);
    // not IP, and one tag more than allowed
    run_frame(0, 16'h1234, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 6, 0, 1'b1);
    run_frame(3, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 4, 0, 1'b0);
    // IPv4: echo even and odd, IHL below five, options, other protocol and type
    run_frame(2, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0000, 0, 0, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'hFFFF, 10, 0, 1'b0);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd0, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0002, 8, 0, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd4, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0002, 8, 0, 1'b1);
    run_frame(1, pecc_pkg::ETYPE_IPV4, 4'd15, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h1234, 3, 0, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, 8'd6, pecc_pkg::ICMPV4_PING_REQ,
              16'h0010, 5, 0, 1'b0);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, 8'd0,
              16'h0010, 5, 0, 1'b1);
    // short ICMP header, short IP header
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0010, 0, 39, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV4, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV4_PING_REQ,
              16'h0010, 0, 24, 1'b0);
    // IPv6 cases
    run_frame(0, pecc_pkg::ETYPE_IPV6, 4'd5, pecc_pkg::PROTO_ICMPV6, pecc_pkg::ICMPV6_PING_REQ,
              16'h8000, 2, 0, 1'b1);
    run_frame(1, pecc_pkg::ETYPE_IPV6, 4'd5, pecc_pkg::PROTO_ICMPV6, pecc_pkg::ICMPV6_PING_REQ,
              16'h7FFF, 0, 0, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV6, 4'd5, pecc_pkg::PROTO_ICMP, pecc_pkg::ICMPV6_PING_REQ,
              16'h0004, 2, 0, 1'b0);
    run_frame(2, pecc_pkg::ETYPE_IPV6, 4'd5, pecc_pkg::PROTO_ICMPV6, pecc_pkg::ICMPV4_PING_REQ,
              16'h0004, 2, 0, 1'b1);
    run_frame(0, pecc_pkg::ETYPE_IPV6, 4'd5, pecc_pkg::PROTO_ICMPV6, pecc_pkg::ICMPV6_PING_REQ,
              16'h0004, 0, 44, 1'b1);

    while (bytes_sent < 1500 || frames_sent < 30) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // raw noise frame
        frame_bytes.delete();
        repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
        send_frame($urandom_range(0, 9) < 7);
      end else begin
        r = $urandom_range(0, 9);
        n_tags = (r < 5) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
        r = $urandom_range(0, 19);
        l3_type = (r < 9) ? pecc_pkg::ETYPE_IPV4 : (r < 17) ? pecc_pkg::ETYPE_IPV6 :
                  (r == 17) ? pecc_pkg::TPID_CTAG : 16'($urandom);
        r = $urandom_range(0, 9);
        ihl = (r < 8) ? 4'd5 : (r == 8) ? 4'($urandom_range(6, 15)) : 4'($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 85)
          proto = (l3_type == pecc_pkg::ETYPE_IPV6) ? pecc_pkg::PROTO_ICMPV6
                                                    : pecc_pkg::PROTO_ICMP;
        else
          proto = 8'($urandom);
        if ($urandom_range(0, 99) < 80)
          icmp_type = (l3_type == pecc_pkg::ETYPE_IPV6) ? pecc_pkg::ICMPV6_PING_REQ
                                                        : pecc_pkg::ICMPV4_PING_REQ;
        else
          icmp_type = 8'($urandom);
        cut_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : 0;
        run_frame(n_tags, l3_type, ihl, proto, icmp_type, 16'($urandom),
                  $urandom_range(0, 24), cut_len, $urandom_range(0, 9) < 7);
      end
    end
    in_push <= 1'b0;

    @(negedge clk);
    while (verdicts_open != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_ping_echo_packet_classifier_core: clean");
    end else begin
      $display("tb_ping_echo_packet_classifier_core: errors");
    end
    $finish;
  end

endmodule

@@ ping_echo_packet_classifier_core.f @@
+incdir+src
src/pecc_pkg.sv
src/pecc_front.sv
src/pecc_queue.sv
src/pecc_back.sv
src/ping_echo_packet_classifier_core.sv
src/pecc_checker.sv
tb/pecc_verdict_checker.sv
tb/tb_ping_echo_packet_classifier_core.sv
